// ===== hw/rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Shared types and codes for the scheduler controller, datapath and top level.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SWITCH = 3'd1,
    OP_SLEEP  = 3'd2,
    OP_WAIT   = 3'd3,
    OP_SIGNAL = 3'd4,
    OP_INIT   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWITCH,
    ST_RELEASE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         sem_id;
    logic [31:0]        sleep_ticks;
    logic signed [31:0] init_count;
  } in_t;

  typedef struct packed {
    logic [2:0]         running_thread;
    logic               none_runnable;
    logic               caller_blocked;
    logic signed [31:0] sem_count;
    logic               no_waiter;
  } out_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic step_switch;
    logic step_release;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_switch;
    logic need_release;
    logic hit_run;
    logic hit_waiter;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Round-robin thread scheduler controller
// Sequences accept, execute, ring search and result transfer for each command.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rrts_pkg::status_t  status_i,
  output rrts_pkg::cmd_t     cmd_o
);

  rrts_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rrts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rrts_pkg::ST_EXEC;
        end
      end
      rrts_pkg::ST_EXEC: begin
        if (status_i.need_switch) begin
          state_d = rrts_pkg::ST_SWITCH;
        end else if (status_i.need_release) begin
          state_d = rrts_pkg::ST_RELEASE;
        end else begin
          state_d = rrts_pkg::ST_RESULT;
        end
      end
      rrts_pkg::ST_SWITCH: begin
        if (status_i.hit_run || status_i.last) begin
          state_d = rrts_pkg::ST_RESULT;
        end
      end
      rrts_pkg::ST_RELEASE: begin
        if (status_i.hit_waiter || status_i.last) begin
          state_d = rrts_pkg::ST_RESULT;
        end
      end
      rrts_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          state_d = rrts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      rrts_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.accept  = in_valid_i;
      end
      rrts_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      rrts_pkg::ST_SWITCH: begin
        cmd_o.step_switch = 1'b1;
      end
      rrts_pkg::ST_RELEASE: begin
        cmd_o.step_release = 1'b1;
      end
      rrts_pkg::ST_RESULT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rrts_datapath.sv =====
// ----------------------------------------------------------------------------
// Round-robin thread scheduler datapath
// Holds thread and semaphore state, the ring search cursor and the result.
// ----------------------------------------------------------------------------
module rrts_datapath #(
  parameter int THREADS    = 6,
  parameter int SEMAPHORES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrts_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rrts_pkg::out_t    out_data_o,
  input  rrts_pkg::cmd_t    cmd_i,
  output rrts_pkg::status_t status_o
);

  localparam int ThrW     = $clog2(THREADS);
  localparam int CntW     = $clog2(THREADS + 1);
  localparam int SemDepth = (SEMAPHORES < 8) ? SEMAPHORES : 8;
  localparam int SemIdxW  = (SemDepth > 1) ? $clog2(SemDepth) : 1;
  localparam logic signed [31:0] SemMin = 32'sh8000_0000;
  localparam logic signed [31:0] SemMax = 32'sh7fff_ffff;

  logic [ThrW-1:0]    cur_q;
  logic [31:0]        sleep_q   [THREADS];
  logic [THREADS-1:0] blocked_q;
  logic [2:0]         bsem_q    [THREADS];
  logic signed [31:0] sem_q     [SemDepth];
  logic               out_valid_q;

  rrts_pkg::in_t      req_q;
  rrts_pkg::out_t     out_q;
  logic [ThrW-1:0]    t_q;
  logic [CntW-1:0]    k_q;
  logic               blk_q;
  logic               show_q;
  logic signed [31:0] cnt_q;
  logic               nowait_q;

  logic [THREADS-1:0] runnable;
  logic [SemIdxW-1:0] sem_idx;
  logic               sem_ok;
  logic               sem_op;
  logic signed [31:0] sem_rd;
  logic signed [31:0] sem_dec;
  logic signed [31:0] sem_inc;
  logic signed [31:0] sem_new;
  logic               wait_blocks;
  logic               need_release;
  logic [ThrW-1:0]    t_first;
  logic [ThrW-1:0]    t_next;
  logic               hit_run;
  logic               hit_waiter;

  always_comb begin
    for (int i = 0; i < THREADS; i++) begin
      runnable[i] = !blocked_q[i] && (sleep_q[i] == 32'd0);
    end
  end

  assign sem_idx = req_q.sem_id[SemIdxW-1:0];
  assign sem_ok  = int'(req_q.sem_id) < SEMAPHORES;
  assign sem_rd  = sem_q[sem_idx];
  assign sem_dec = (sem_rd == SemMin) ? sem_rd : sem_rd - 32'sd1;
  assign sem_inc = (sem_rd == SemMax) ? sem_rd : sem_rd + 32'sd1;

  always_comb begin
    sem_op  = 1'b0;
    sem_new = sem_rd;
    case (req_q.operation)
      rrts_pkg::OP_WAIT: begin
        sem_op  = sem_ok;
        sem_new = sem_dec;
      end
      rrts_pkg::OP_SIGNAL: begin
        sem_op  = sem_ok;
        sem_new = sem_inc;
      end
      rrts_pkg::OP_INIT: begin
        sem_op  = sem_ok;
        sem_new = req_q.init_count;
      end
      default: begin
        sem_op  = 1'b0;
        sem_new = sem_rd;
      end
    endcase
  end

  assign wait_blocks  = (req_q.operation == rrts_pkg::OP_WAIT) && sem_ok && sem_dec[31];
  assign need_release = (req_q.operation == rrts_pkg::OP_SIGNAL) && sem_ok &&
                        (sem_inc[31] || (sem_inc == 32'sd0));

  assign t_first    = (cur_q == ThrW'(THREADS - 1)) ? '0 : cur_q + 1'b1;
  assign t_next     = (t_q == ThrW'(THREADS - 1)) ? '0 : t_q + 1'b1;
  assign hit_run    = runnable[t_q];
  assign hit_waiter = blocked_q[t_q] && (bsem_q[t_q] == req_q.sem_id);

  assign status_o.need_switch  = (req_q.operation == rrts_pkg::OP_SWITCH) ||
                                 (req_q.operation == rrts_pkg::OP_SLEEP) || wait_blocks;
  assign status_o.need_release = need_release;
  assign status_o.hit_run      = hit_run;
  assign status_o.hit_waiter   = hit_waiter;
  assign status_o.last         = (k_q == CntW'(THREADS));
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      blocked_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        sleep_q[i] <= '0;
        bsem_q[i]  <= '0;
      end
      for (int s = 0; s < SemDepth; s++) begin
        sem_q[s] <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        case (req_q.operation)
          rrts_pkg::OP_TICK: begin
            for (int i = 0; i < THREADS; i++) begin
              if (sleep_q[i] != 32'd0) begin
                sleep_q[i] <= sleep_q[i] - 32'd1;
              end
            end
          end
          rrts_pkg::OP_SLEEP: begin
            sleep_q[cur_q] <= req_q.sleep_ticks;
          end
          rrts_pkg::OP_WAIT, rrts_pkg::OP_SIGNAL, rrts_pkg::OP_INIT: begin
            if (sem_ok) begin
              sem_q[sem_idx] <= sem_new;
            end
            if (wait_blocks) begin
              blocked_q[cur_q] <= 1'b1;
              bsem_q[cur_q]    <= req_q.sem_id;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.step_switch && hit_run) begin
        cur_q <= t_q;
      end
      if (cmd_i.step_release && hit_waiter) begin
        blocked_q[t_q] <= 1'b0;
        bsem_q[t_q]    <= '0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_data_i;
    end
    if (cmd_i.exec) begin
      t_q      <= t_first;
      k_q      <= CntW'(1);
      blk_q    <= wait_blocks;
      show_q   <= sem_op;
      cnt_q    <= sem_new;
      nowait_q <= need_release;
    end
    if (cmd_i.step_switch || cmd_i.step_release) begin
      t_q <= t_next;
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.step_release && hit_waiter) begin
      nowait_q <= 1'b0;
    end
    if (cmd_i.load_out) begin
      out_q.running_thread <= 3'(cur_q);
      out_q.none_runnable  <= ~|runnable;
      out_q.caller_blocked <= blk_q;
      out_q.sem_count      <= show_q ? cnt_q : 32'sd0;
      out_q.no_waiter      <= nowait_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/round_robin_thread_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Round-robin thread scheduler unit
// Thread scheduler with sleep counters and counting semaphores over a ring.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  in_data_i   (rrts_pkg::in_t)
//   out      output     out_valid_o/out_stall_i out_data_o (rrts_pkg::out_t)
//
// A command that needs a ring search examines up to THREADS threads, one
// thread per cycle.
// One command is in progress at a time; the next transfer is taken once the
// result is in the output register, even while that result is stalled.
// Reset clears all thread state, semaphore counts and the running thread.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit #(
  parameter int THREADS    = 6,
  parameter int SEMAPHORES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rrts_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rrts_pkg::out_t out_data_o
);

  rrts_pkg::cmd_t    cmd;
  rrts_pkg::status_t status;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrts_datapath #(
    .THREADS    (THREADS),
    .SEMAPHORES (SEMAPHORES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
